[rtl/assert_macros.svh]
// Assertion macros. Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT(label, prop)

`define ASSERT_NEVER(label, cond)

`endif

`endif

[rtl/mmcal_pkg.sv]
package mmcal_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned GAIN_FRAC_DEF   = 16;
  localparam int unsigned GAIN_W          = 24;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_ADDR_W      = 1;
  localparam int unsigned CNT_W           = 16;
  localparam int unsigned STEP_W          = $clog2(GAIN_W);

  localparam logic [CFG_ADDR_W-1:0] REG_UPDATE_PERIOD = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPAN      = 1'b1;

  localparam logic [CFG_W-1:0] UPDATE_PERIOD_RST = 16'd100;
  localparam logic [CFG_W-1:0] MIN_SPAN_RST      = 16'd100;

  typedef struct packed {
    logic capture;
    logic update;
    logic span_load;
    logic div_load;
    logic div_step;
    logic gain_write;
    logic emit;
  } mmcal_cmd_t;

  typedef struct packed {
    logic refresh_ok;
  } mmcal_status_t;

endpackage

[rtl/mmcal_datapath.sv]
module mmcal_datapath #(
  parameter int unsigned SAMPLE_BITS    = mmcal_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = mmcal_pkg::GAIN_FRAC_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [mmcal_pkg::CFG_ADDR_W-1:0]             cfg_addr_i,
  input  logic [mmcal_pkg::CFG_W-1:0]                  cfg_wdata_i,
  input  logic [2:0][SAMPLE_BITS-1:0]                  mag_i,
  input  mmcal_pkg::mmcal_cmd_t                        cmd_i,
  output mmcal_pkg::mmcal_status_t                     status_o,
  output logic [2:0][SAMPLE_BITS-1:0]                  offset_o,
  output logic [2:0][mmcal_pkg::GAIN_W-1:0]            gain_o,
  output logic                                         refreshed_o
);
  import mmcal_pkg::*;

  localparam int unsigned SPAN_W = SAMPLE_BITS + 1;
  localparam int unsigned SUM_W  = SAMPLE_BITS + 3;
  localparam int unsigned DEN_W  = SAMPLE_BITS + 3;
  localparam int unsigned REM_W  = DEN_W + 1;
  localparam int unsigned NUM_W  = SUM_W + GAIN_FRAC_BITS;
  localparam int unsigned HI_W   = (NUM_W > GAIN_W) ? NUM_W - GAIN_W : 1;
  localparam int unsigned NUMX_W = HI_W + GAIN_W;
  localparam int unsigned CMP_W  = (SPAN_W > CFG_W) ? SPAN_W : CFG_W;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [GAIN_W-1:0]             GAIN_ONE      = GAIN_W'(1) << GAIN_FRAC_BITS;

  logic [CFG_W-1:0]              period_q;
  logic [CFG_W-1:0]              min_span_q;
  logic signed [SAMPLE_BITS-1:0] mag_q [3];
  logic signed [SAMPLE_BITS-1:0] min_q [3];
  logic signed [SAMPLE_BITS-1:0] max_q [3];
  logic [CNT_W-1:0]              cnt_q;
  logic [CNT_W-1:0]              cnt_d;
  logic                          due_q;
  logic [SPAN_W-1:0]             span_q [3];
  logic [SPAN_W-1:0]             span_d [3];
  logic [SUM_W-1:0]              sum_q;
  logic [SUM_W-1:0]              sum_d;
  logic signed [SAMPLE_BITS-1:0] off_q [3];
  logic [SAMPLE_BITS-1:0]        off_d [3];
  logic [GAIN_W-1:0]             gain_q [3];
  logic [DEN_W-1:0]              den_q [3];
  logic [DEN_W-1:0]              den_d [3];
  logic [REM_W-1:0]              rem_q [3];
  logic [REM_W-1:0]              rem_d [3];
  logic [REM_W-1:0]              shl [3];
  logic [GAIN_W-1:0]             quo_q [3];
  logic                          sat_q [3];
  logic                          sat_d [3];
  logic [GAIN_W-1:0]             numlo_q;
  logic [NUMX_W-1:0]             num;
  logic [HI_W-1:0]               num_hi;
  logic                          refreshed_q;
  logic [2:0][SAMPLE_BITS-1:0]   out_off_q;
  logic [2:0][GAIN_W-1:0]        out_gain_q;
  logic                          out_ref_q;
  logic [2:0]                    span_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= UPDATE_PERIOD_RST;
      min_span_q <= MIN_SPAN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_UPDATE_PERIOD: period_q   <= cfg_wdata_i;
        REG_MIN_SPAN:      min_span_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q + CNT_W'(1);
    num   = NUMX_W'(sum_q) << GAIN_FRAC_BITS;
    num_hi = num[NUMX_W-1:GAIN_W];
    sum_d = '0;
    for (int i = 0; i < 3; i++) begin
      logic signed [SAMPLE_BITS:0] diff;
      logic signed [SAMPLE_BITS:0] mid;
      diff = $signed({max_q[i][SAMPLE_BITS-1], max_q[i]})
           - $signed({min_q[i][SAMPLE_BITS-1], min_q[i]});
      mid  = $signed({max_q[i][SAMPLE_BITS-1], max_q[i]})
           + $signed({min_q[i][SAMPLE_BITS-1], min_q[i]});
      span_d[i]  = (diff > 0) ? SPAN_W'(diff) : '0;
      sum_d      = sum_d + SUM_W'(span_d[i]);
      off_d[i]   = mid[SAMPLE_BITS:1];
      span_ok[i] = CMP_W'(span_q[i]) >= CMP_W'(min_span_q);
      den_d[i]   = DEN_W'(span_q[i]) + (DEN_W'(span_q[i]) << 1);
      sat_d[i]   = (den_d[i] == '0) || (REM_W'(num_hi) >= REM_W'(den_d[i]));
      shl[i]     = {rem_q[i][REM_W-2:0], numlo_q[GAIN_W-1]};
      rem_d[i]   = shl[i] - REM_W'(den_q[i]);
    end
  end

  assign status_o.refresh_ok = due_q && (&span_ok);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= $signed(mag_i[i]);
      end
    end
    if (cmd_i.span_load) begin
      span_q <= span_d;
      sum_q  <= sum_d;
    end
    if (cmd_i.div_load) begin
      numlo_q <= num[GAIN_W-1:0];
    end else if (cmd_i.div_step) begin
      numlo_q <= numlo_q << 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.div_load) begin
        den_q[i] <= den_d[i];
        rem_q[i] <= REM_W'(num_hi);
        sat_q[i] <= sat_d[i];
        quo_q[i] <= '0;
      end else if (cmd_i.div_step) begin
        if (shl[i] >= REM_W'(den_q[i])) begin
          rem_q[i] <= rem_d[i];
          quo_q[i] <= {quo_q[i][GAIN_W-2:0], 1'b1};
        end else begin
          rem_q[i] <= shl[i];
          quo_q[i] <= {quo_q[i][GAIN_W-2:0], 1'b0};
        end
      end
    end
    if (cmd_i.emit) begin
      for (int i = 0; i < 3; i++) begin
        out_off_q[i]  <= off_q[i];
        out_gain_q[i] <= gain_q[i];
      end
      out_ref_q <= refreshed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      due_q       <= 1'b0;
      refreshed_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        min_q[i]  <= SAMPLE_TOP;
        max_q[i]  <= SAMPLE_BOTTOM;
        off_q[i]  <= '0;
        gain_q[i] <= GAIN_ONE;
      end
    end else begin
      if (cmd_i.capture) begin
        refreshed_q <= 1'b0;
      end
      if (cmd_i.update) begin
        for (int i = 0; i < 3; i++) begin
          if (mag_q[i] < min_q[i]) begin
            min_q[i] <= mag_q[i];
          end
          if (mag_q[i] > max_q[i]) begin
            max_q[i] <= mag_q[i];
          end
        end
        if (cnt_d >= period_q) begin
          cnt_q <= '0;
          due_q <= 1'b1;
        end else begin
          cnt_q <= cnt_d;
          due_q <= 1'b0;
        end
      end
      if (cmd_i.div_load) begin
        refreshed_q <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          off_q[i] <= $signed(off_d[i]);
        end
      end
      if (cmd_i.gain_write) begin
        for (int i = 0; i < 3; i++) begin
          gain_q[i] <= sat_q[i] ? {GAIN_W{1'b1}} : quo_q[i];
        end
      end
    end
  end

  assign offset_o    = out_off_q;
  assign gain_o      = out_gain_q;
  assign refreshed_o = out_ref_q;

endmodule

[rtl/mmcal_ctrl.sv]
`include "assert_macros.svh"

module mmcal_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  mmcal_pkg::mmcal_status_t status_i,
  output mmcal_pkg::mmcal_cmd_t    cmd_o
);
  import mmcal_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_SPAN   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_GAIN   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GAIN_W - 1);

  logic [2:0]        state_q;
  logic [2:0]        state_d;
  logic [STEP_W-1:0] step_q;
  logic [STEP_W-1:0] step_d;
  logic              out_valid_q;
  logic              out_valid_d;
  logic              slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_SPAN;
      end
      S_SPAN: begin
        cmd_o.span_load = 1'b1;
        state_d         = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.refresh_ok) begin
          cmd_o.div_load = 1'b1;
          step_d         = '0;
          state_d        = S_DIV;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd_o.gain_write = 1'b1;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `ASSERT(a_accept_starts_update, (in_valid_i && in_ready_o) |=> (state_q == S_UPDATE))
  `ASSERT(a_div_length, (state_q == S_DIV && step_q == LAST_STEP) |=> (state_q == S_GAIN))
  `ASSERT(a_gain_after_div, (state_q == S_GAIN) |-> ($past(state_q) == S_DIV))
  `ASSERT_NEVER(a_emit_overwrites, cmd_o.emit && out_valid_q && !out_ready_i)

endmodule

[rtl/magnetometer_minmax_calibrator_top.sv]
// Channel   | Direction | tdata (lowest bit first)                 | tuser
// s_axis    | in        | mag_x, mag_y, mag_z                      | none
// m_axis    | out       | offset_x..offset_z, gain_x..gain_z, pad  | refreshed
// cfg       | in        | index 0 update_period, 1 min_span        | none
//
// Without a refresh, a sample passes capture, min/max update, span load, check and emit.
// A refresh adds a 24-step restoring divider on all three axes at once and then a gain write.
// The result sits in an output register, so a new sample is taken while it waits.
// Reset restores the default registers, an empty min/max record and a unity calibration.
module magnetometer_minmax_calibrator_top #(
  parameter int unsigned SAMPLE_BITS    = mmcal_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = mmcal_pkg::GAIN_FRAC_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [mmcal_pkg::CFG_ADDR_W-1:0]         cfg_addr_i,
  input  logic [mmcal_pkg::CFG_W-1:0]              cfg_wdata_i,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // mag_x, mag_y, mag_z
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // offset_x, offset_y, offset_z, gain_x, gain_y, gain_z, zero fill
  output logic [((3*SAMPLE_BITS+3*mmcal_pkg::GAIN_W+7)/8)*8-1:0] m_axis_tdata,
  // refreshed
  output logic                                     m_axis_tuser
);
  import mmcal_pkg::*;

  localparam int unsigned OUT_W = ((3*SAMPLE_BITS+3*GAIN_W+7)/8)*8;

  logic [2:0][SAMPLE_BITS-1:0] mag;
  logic [2:0][SAMPLE_BITS-1:0] offset;
  logic [2:0][GAIN_W-1:0]      gain;
  mmcal_cmd_t                  cmd;
  mmcal_status_t               status;

  assign mag = s_axis_tdata[3*SAMPLE_BITS-1:0];

  mmcal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mmcal_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mag_i       (mag),
    .cmd_i       (cmd),
    .status_o    (status),
    .offset_o    (offset),
    .gain_o      (gain),
    .refreshed_o (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_W'({gain, offset});

endmodule
